>>> rtl/itda_pkg.sv
// itda_pkg: shared types and constants for the integer to decimal ASCII block.
// Used by the queue, the front and the back modules; no dependencies.

package itda_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'

  // Double-dabble correction: a BCD digit of five or more gets three added
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ       = 4'd3;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_SIGN,
    BK_DIGITS
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/itda_if.sv
// itda_if: valid/ready channel interfaces for the decimal ASCII block.
// itda_in_if carries one integer, itda_out_if carries one character.

interface itda_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

>>> rtl/itda_queue.sv
// itda_queue: two-entry queue of classified items between front and back.
// Depends on itda_pkg for the status struct.

module itda_queue #(
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic [WIDTH-1:0]         pop_data,
  output itda_pkg::queue_status_t  status
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/itda_front.sv
// itda_front: accepts integers, splits them into sign and unsigned magnitude.
// Depends on itda_pkg and itda_if; feeds itda_queue.

module itda_front #(
  parameter int DATA_WIDTH = 32
) (
  itda_in_if.sink                  in_ch,
  input  itda_pkg::queue_status_t  status,
  output logic                     push,
  output logic                     push_neg,
  output logic [DATA_WIDTH-1:0]    push_mag
);

  logic [DATA_WIDTH-1:0] raw;

  assign raw         = DATA_WIDTH'(in_ch.value);
  assign in_ch.ready = !status.full;
  assign push        = in_ch.valid && !status.full;
  assign push_neg    = raw[DATA_WIDTH-1];
  // Unsigned negate: the most negative value maps onto its true magnitude
  assign push_mag    = push_neg ? (~raw + DATA_WIDTH'(1)) : raw;

endmodule

>>> rtl/itda_back.sv
// itda_back: bit-serial binary to BCD conversion, then character emission.
// Depends on itda_pkg and itda_if; drains itda_queue.

module itda_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  itda_pkg::queue_status_t  status,
  output logic                     pop,
  input  logic                     pop_neg,
  input  logic [DATA_WIDTH-1:0]    pop_mag,
  itda_out_if.source               out_ch
);

  // Decimal digits of 2^DATA_WIDTH - 1 (log10(2) ~ 0.30103)
  localparam int NDIG = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int BW   = NDIG * 4;
  localparam int CW   = $clog2(DATA_WIDTH + 1);
  localparam int RW   = $clog2(NDIG + 1);

  itda_pkg::back_state_t state_r, state_nxt;
  logic [DATA_WIDTH-1:0] mag_r, mag_nxt;
  logic [BW-1:0]         bcd_r, bcd_nxt, bcd_adj;
  logic                  neg_r, neg_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic                  started_r, started_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  slot_free;
  logic [3:0]            top_digit;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;
  assign slot_free        = !out_valid_r || out_ch.ready;
  assign top_digit        = bcd_r[BW-1 -: 4];

  // Per-digit add-three correction, digits are independent
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] >= itda_pkg::BCD_ADJ_LIMIT) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + itda_pkg::BCD_ADJ;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    started_nxt   = started_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pop           = 1'b0;

    case (state_r)
      itda_pkg::BK_IDLE: begin
        if (!status.empty) begin
          pop       = 1'b1;
          mag_nxt   = pop_mag;
          neg_nxt   = pop_neg;
          bcd_nxt   = '0;
          cnt_nxt   = CW'(DATA_WIDTH);
          state_nxt = itda_pkg::BK_CONV;
        end
      end
      itda_pkg::BK_CONV: begin
        bcd_nxt = {bcd_adj[BW-2:0], mag_r[DATA_WIDTH-1]};
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          rem_nxt     = RW'(NDIG);
          started_nxt = 1'b0;
          state_nxt   = neg_r ? itda_pkg::BK_SIGN : itda_pkg::BK_DIGITS;
        end
      end
      itda_pkg::BK_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itda_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = itda_pkg::BK_DIGITS;
        end
      end
      itda_pkg::BK_DIGITS: begin
        if (!started_r && top_digit == 4'd0 && rem_r != RW'(1)) begin
          // Drop a leading zero
          bcd_nxt = bcd_r << 4;
          rem_nxt = rem_r - RW'(1);
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itda_pkg::CHAR_ZERO | {4'd0, top_digit};
          out_last_nxt  = (rem_r == RW'(1));
          started_nxt   = 1'b1;
          bcd_nxt       = bcd_r << 4;
          rem_nxt       = rem_r - RW'(1);
          if (rem_r == RW'(1)) begin
            state_nxt = itda_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itda_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itda_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> rtl/int_to_decimal_ascii_top.sv
// int_to_decimal_ascii_top: signed integer to decimal ASCII text converter.
// Instantiates itda_front, itda_queue and itda_back; uses itda_pkg, itda_if.
//
// Usage:
//   in_ch  (valid/ready) takes one two's-complement integer of DATA_WIDTH
//          bits per item.
//   out_ch (valid/ready) gives the text one character per item: '-' first
//          for a negative value, then the digits most significant first,
//          no leading zeros; zero gives a single '0'. last marks the final
//          character of each value. No terminator is sent.
// Flow: an accepted item is written into the queue; the back end pops it
//   when idle, shifts all DATA_WIDTH magnitude bits through the bit-serial
//   binary to BCD converter (one magnitude bit per cycle), then emits the
//   characters in turn, dropping leading zeros. The back end takes no new
//   item before the last character of the previous one is registered.
// Queueing: while the back end is busy, the front takes items
//   into a two-entry queue, so up to two further items are held before
//   in_ch.ready falls.
// Reset: rst_n (synchronous, active low) empties the queue, clears the
//   output valid flag and returns the back end to idle.
// Stall: when out_ch.ready is low the current character holds in the
//   output register and emission of the next character waits.

module int_to_decimal_ascii_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  itda_in_if.sink    in_ch,
  itda_out_if.source out_ch
);

  localparam int QW = DATA_WIDTH + 1;

  itda_pkg::queue_status_t q_status;
  logic                    push, pop;
  logic                    push_neg;
  logic [DATA_WIDTH-1:0]   push_mag;
  logic [QW-1:0]           pop_data;

  // Classify: sign flag and unsigned magnitude
  itda_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .in_ch    (in_ch),
    .status   (q_status),
    .push     (push),
    .push_neg (push_neg),
    .push_mag (push_mag)
  );

  // Decouple the accept side from the conversion side
  itda_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_neg, push_mag}),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Convert to BCD and stream the characters out
  itda_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .status  (q_status),
    .pop     (pop),
    .pop_neg (pop_data[QW-1]),
    .pop_mag (pop_data[DATA_WIDTH-1:0]),
    .out_ch  (out_ch)
  );

endmodule
